// ----- rtl/jfp_pkg.sv -----
`timescale 1ns / 1ps

package jfp_pkg;

    localparam int MAX_SIDE_DEF    = 32;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int GRID_RESET      = 32;
    localparam int MIN_SIDE        = 3;
    localparam int QUEUE_DEPTH     = 4;

    // what a queued job has to emit
    typedef struct packed {
        logic has_int;   // interior cell one row up
        logic has_bdr;   // border cell, the sample itself
    } t_kind;

endpackage

// ----- rtl/jfp_stream_if.sv -----
`timescale 1ns / 1ps

interface jfp_in_if #(
    parameter int SAMPLE_BITS = jfp_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface jfp_out_if #(
    parameter int MAX_SIDE    = jfp_pkg::MAX_SIDE_DEF,
    parameter int SAMPLE_BITS = jfp_pkg::SAMPLE_BITS_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic [$clog2(MAX_SIDE)-1:0]    col;
    logic [$clog2(MAX_SIDE)-1:0]    row;
    logic signed [SAMPLE_BITS-1:0]  result;
    logic                           last_in_run;

    modport source (output valid, output col, output row, output result,
                    output last_in_run, input ready);
    modport sink   (input valid, input col, input row, input result,
                    input last_in_run, output ready);
endinterface

// ----- rtl/jfp_front.sv -----
`timescale 1ns / 1ps

module jfp_front #(
    parameter int MAX_SIDE    = jfp_pkg::MAX_SIDE_DEF,
    parameter int SAMPLE_BITS = jfp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [$clog2(MAX_SIDE+1)-1:0]        i_cfg_wr_data,
    jfp_in_if.sink                               i_in,
    output logic                                 o_push,
    output logic [$clog2(MAX_SIDE)-1:0]          o_col,
    output logic [$clog2(MAX_SIDE)-1:0]          o_row,
    output logic [SAMPLE_BITS-1:0]               o_sample,
    output logic [SAMPLE_BITS-1:0]               o_avg,
    output jfp_pkg::t_kind                       o_kind,
    input  logic                                 i_full
);
    import jfp_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int DW = SAMPLE_BITS;

    logic [SW-1:0] r_grid;
    logic [SW-1:0] side;
    logic [SW-1:0] side_m1;
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic          r_sel;

    logic          col_first, col_last, row_first, row_last;
    logic [CW-1:0] col_dn, col_up;
    logic [CW-1:0] addr_ax, addr_bx;
    logic          accept;
    t_kind         kind;

    // stage 1: classified item plus registered buffer reads
    logic          r_s1_valid;
    logic          r_s1_sel;
    logic [CW-1:0] r_s1_col;
    logic [CW-1:0] r_s1_row;
    logic [DW-1:0] r_s1_sample;
    t_kind         r_s1_kind;
    logic          need_push;
    logic          s1_free;

    logic [DW-1:0] r_mem_a [MAX_SIDE];
    logic [DW-1:0] r_mem_b [MAX_SIDE];
    logic [DW-1:0] r_rd_ax, r_rd_ay, r_rd_bx, r_rd_by;

    logic [DW-1:0]   up, left, right;
    logic [DW+1:0]   sum;

    always_comb begin
        if (r_grid < SW'(MIN_SIDE)) begin
            side = SW'(MIN_SIDE);
        end else if (r_grid > SW'(MAX_SIDE)) begin
            side = SW'(MAX_SIDE);
        end else begin
            side = r_grid;
        end
    end

    assign side_m1   = side - SW'(1);
    assign col_first = (r_col == '0);
    assign row_first = (r_row == '0);
    assign col_last  = (SW'(r_col) == side_m1);
    assign row_last  = (SW'(r_row) == side_m1);

    assign kind.has_int = (r_row >= CW'(2)) && !col_first && !col_last;
    assign kind.has_bdr = row_first || row_last || col_first || col_last;

    // items that make no result are dropped here and never queued
    assign need_push  = r_s1_valid && (r_s1_kind.has_int || r_s1_kind.has_bdr);
    assign s1_free    = !r_s1_valid || !need_push || !i_full;
    assign i_in.ready = s1_free;
    assign accept     = i_in.valid && s1_free;
    assign o_push     = need_push && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid     <= SW'(GRID_RESET);
            r_col      <= '0;
            r_row      <= '0;
            r_sel      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_grid <= i_cfg_wr_data;
                r_col  <= '0;
                r_row  <= '0;
                r_sel  <= 1'b0;
            end else if (accept) begin
                if (col_last) begin
                    r_col <= '0;
                    if (row_last) begin
                        r_row <= '0;
                        r_sel <= 1'b0;
                    end else begin
                        r_row <= r_row + CW'(1);
                        r_sel <= ~r_sel;
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (s1_free) begin
                r_s1_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sel    <= r_sel;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_sample <= i_in.sample;
            r_s1_kind   <= kind;
        end
    end

    // Current-row buffer is read at col (holds row r-2), previous-row buffer
    // at col-1 and col+1. Read happens before the write of the same edge.
    assign col_dn  = r_col - CW'(1);
    assign col_up  = r_col + CW'(1);
    assign addr_ax = r_sel ? col_dn : r_col;
    assign addr_bx = r_sel ? r_col : col_dn;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_ax <= r_mem_a[addr_ax];
            r_rd_ay <= r_mem_a[col_up];
            r_rd_bx <= r_mem_b[addr_bx];
            r_rd_by <= r_mem_b[col_up];
            if (!r_sel) begin
                r_mem_a[r_col] <= i_in.sample;
            end else begin
                r_mem_b[r_col] <= i_in.sample;
            end
        end
    end

    assign up    = r_s1_sel ? r_rd_bx : r_rd_ax;
    assign left  = r_s1_sel ? r_rd_ax : r_rd_bx;
    assign right = r_s1_sel ? r_rd_ay : r_rd_by;

    assign sum = {{2{left[DW-1]}}, left} + {{2{right[DW-1]}}, right}
               + {{2{up[DW-1]}}, up} + {{2{r_s1_sample[DW-1]}}, r_s1_sample};

    assign o_col    = r_s1_col;
    assign o_row    = r_s1_row;
    assign o_sample = r_s1_sample;
    assign o_avg    = sum[DW+1:2];   // arithmetic shift by two, floor
    assign o_kind   = r_s1_kind;

endmodule

// ----- rtl/jfp_queue.sv -----
`timescale 1ns / 1ps

module jfp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = jfp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import jfp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/jfp_back.sv -----
`timescale 1ns / 1ps

module jfp_back #(
    parameter int MAX_SIDE    = jfp_pkg::MAX_SIDE_DEF,
    parameter int SAMPLE_BITS = jfp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  logic [$clog2(MAX_SIDE)-1:0] i_col,
    input  logic [$clog2(MAX_SIDE)-1:0] i_row,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    input  logic [SAMPLE_BITS-1:0]      i_avg,
    input  jfp_pkg::t_kind              i_kind,
    output logic                        o_pop,
    jfp_out_if.source                   o_out
);
    import jfp_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int DW = SAMPLE_BITS;

    logic          r_valid;
    logic          r_half;      // interior half of a two-result job already sent
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [DW-1:0] r_result;
    logic          r_last;

    logic load, take, send_int;

    assign load     = !r_valid || o_out.ready;
    assign take     = load && !i_empty;
    assign send_int = i_kind.has_int && !r_half;
    assign o_pop    = take && !(send_int && i_kind.has_bdr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
            end
            if (take) begin
                r_half <= send_int && i_kind.has_bdr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_col <= i_col;
            if (send_int) begin
                r_row    <= i_row - CW'(1);
                r_result <= i_avg;
                r_last   <= !i_kind.has_bdr;
            end else begin
                r_row    <= i_row;
                r_result <= i_sample;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.col         = r_col;
    assign o_out.row         = r_row;
    assign o_out.result      = r_result;
    assign o_out.last_in_run = r_last;

endmodule

// ----- rtl/jacobi_four_point_stencil_sweep_unit.sv -----
// A result passes the buffer read stage, then the queue and output stage.
// Throughput: one sample per cycle while the output is ready, except on the
// last row, where each interior sample gives two results and the input is
// held back once the 4-entry queue fills. Reset clears counters, row select,
// grid size (32), queue and output valid; line buffers are not cleared, each
// is written first.
`timescale 1ns / 1ps

module jacobi_four_point_stencil_sweep_unit #(
    parameter int MAX_SIDE    = jfp_pkg::MAX_SIDE_DEF,
    parameter int SAMPLE_BITS = jfp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [$clog2(MAX_SIDE+1)-1:0] i_cfg_wr_data,
    jfp_in_if.sink                        i_in,
    jfp_out_if.source                     o_out
);
    import jfp_pkg::*;

    localparam int CW     = $clog2(MAX_SIDE);
    localparam int DW     = SAMPLE_BITS;
    localparam int KW     = $bits(t_kind);
    localparam int JOB_W  = 2 * CW + 2 * DW + KW;

    logic          push, full, pop, empty;
    logic [CW-1:0] f_col, f_row, b_col, b_row;
    logic [DW-1:0] f_sample, f_avg, b_sample, b_avg;
    t_kind         f_kind, b_kind;
    logic [JOB_W-1:0] q_in, q_out;

    jfp_front #(
        .MAX_SIDE    (MAX_SIDE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .o_push        (push),
        .o_col         (f_col),
        .o_row         (f_row),
        .o_sample      (f_sample),
        .o_avg         (f_avg),
        .o_kind        (f_kind),
        .i_full        (full)
    );

    assign q_in = {f_col, f_row, f_sample, f_avg, f_kind};

    jfp_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    assign {b_col, b_row, b_sample, b_avg, b_kind} = q_out;

    jfp_back #(
        .MAX_SIDE    (MAX_SIDE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_col    (b_col),
        .i_row    (b_row),
        .i_sample (b_sample),
        .i_avg    (b_avg),
        .i_kind   (b_kind),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
